[rtl/wsdf_pkg.sv]
package wsdf_pkg;

  // Register and field widths
  localparam int unsigned MAX_LEN_W = 24;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 64;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned LEFT_W    = 4;

  // Reset value of the maximum payload length register
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 24'd4096;

  // Second header byte: mask flag position and extended length codes
  localparam int unsigned           MASK_BIT    = 7;
  localparam logic [6:0]            LEN_CODE_16 = 7'd126;
  localparam logic [6:0]            LEN_CODE_64 = 7'd127;
  localparam logic [LEFT_W-1:0]     EXT16_BYTES = 4'd2;
  localparam logic [LEFT_W-1:0]     EXT64_BYTES = 4'd8;
  localparam logic [LEFT_W-1:0]     KEY_BYTES   = 4'd4;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // One result beat
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_frame;
    logic              length_error;
    logic              empty_frame;
  } result_t;

endpackage

[rtl/websocket_frame_deframer.sv]
// WebSocket frame deframer, receive side.
// Input channel: one stream byte per beat (in_valid / in_stall / in_stream_byte).
// The first header byte is dropped, the second gives the mask flag and length
// code, then an optional 2- or 8-byte big-endian extended length and an
// optional 4-byte masking key follow. Each payload byte leaves on the result
// channel unmasked, the final one flagged with out_last_of_frame. A declared
// length above the maximum gives one beat with out_length_error, a zero length
// one beat with out_empty_frame; header bytes otherwise give no result.
// Configuration: cfg_wr_en writes cfg_wr_data into the maximum payload length
// register at the clock edge; write it only while the block is idle.
// Timing: one byte is accepted every cycle while in_stall is low. A result enters the
// output register at the accepting edge if that register is free or being taken and
// can leave at the next edge; the parser state is a single register stage updated by
// short logic. Stalling: a two-entry output (result register plus skid register) lets
// the block take one more byte while a result waits; in_stall rises only when the skid
// register is occupied, and is a register output.
// Reset (synchronous, rst_n low): the parser expects a first header byte, both
// output entries are empty and the maximum length returns to 4096.
module websocket_frame_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wsdf_pkg::BYTE_W-1:0]        in_stream_byte,
  input  logic                               cfg_wr_en,
  input  logic [wsdf_pkg::MAX_LEN_W-1:0]     cfg_wr_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [wsdf_pkg::BYTE_W-1:0]        out_payload_byte,
  output logic                               out_last_of_frame,
  output logic                               out_length_error,
  output logic                               out_empty_frame
);

  // Parser state
  wsdf_pkg::phase_t                    phase_r, phase_nxt;
  logic [wsdf_pkg::LEN_W-1:0]          len_r, len_nxt;
  logic [wsdf_pkg::LEFT_W-1:0]         left_r, left_nxt;
  logic [wsdf_pkg::KEY_W-1:0]          key_r, key_nxt;
  logic                                mask_en_r, mask_en_nxt;
  logic [wsdf_pkg::MAX_LEN_W-1:0]      remain_r, remain_nxt;
  logic [1:0]                          pos_r, pos_nxt;
  logic [wsdf_pkg::MAX_LEN_W-1:0]      max_len_r;

  // Output queue
  wsdf_pkg::result_t                   out_r, skid_r, res;
  logic                                out_valid_r, skid_valid_r;
  logic                                res_valid;

  // Header completion check
  logic                                chk_en;
  logic [wsdf_pkg::LEN_W-1:0]          chk_len;
  logic [6:0]                          len_code;
  logic [wsdf_pkg::BYTE_W-1:0]         key_byte;

  logic                                in_acc;
  logic                                out_take;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign len_code = in_stream_byte[6:0];

  // Key byte for the current payload position, first key byte first
  always_comb begin
    unique case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next parser state and the result of one byte
  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    key_nxt     = key_r;
    mask_en_nxt = mask_en_r;
    remain_nxt  = remain_r;
    pos_nxt     = pos_r;
    chk_en      = 1'b0;
    chk_len     = len_r;
    res_valid   = 1'b0;
    res         = '0;

    unique case (phase_r)
      wsdf_pkg::PH_HDR1: begin
        mask_en_nxt = in_stream_byte[wsdf_pkg::MASK_BIT];
        key_nxt     = '0;
        if (len_code == wsdf_pkg::LEN_CODE_16) begin
          len_nxt   = '0;
          left_nxt  = wsdf_pkg::EXT16_BYTES;
          phase_nxt = wsdf_pkg::PH_EXTLEN;
        end else if (len_code == wsdf_pkg::LEN_CODE_64) begin
          len_nxt   = '0;
          left_nxt  = wsdf_pkg::EXT64_BYTES;
          phase_nxt = wsdf_pkg::PH_EXTLEN;
        end else begin
          len_nxt = {{(wsdf_pkg::LEN_W-7){1'b0}}, len_code};
          if (in_stream_byte[wsdf_pkg::MASK_BIT]) begin
            left_nxt  = wsdf_pkg::KEY_BYTES;
            phase_nxt = wsdf_pkg::PH_KEY;
          end else begin
            chk_en  = 1'b1;
            chk_len = len_nxt;
          end
        end
      end
      wsdf_pkg::PH_EXTLEN: begin
        len_nxt  = {len_r[wsdf_pkg::LEN_W-9:0], in_stream_byte};
        left_nxt = left_r - 4'd1;
        if (left_r == 4'd1) begin
          if (mask_en_r) begin
            left_nxt  = wsdf_pkg::KEY_BYTES;
            phase_nxt = wsdf_pkg::PH_KEY;
          end else begin
            chk_en  = 1'b1;
            chk_len = len_nxt;
          end
        end
      end
      wsdf_pkg::PH_KEY: begin
        key_nxt  = {key_r[23:0], in_stream_byte};
        left_nxt = left_r - 4'd1;
        if (left_r == 4'd1) begin
          chk_en  = 1'b1;
          chk_len = len_r;
        end
      end
      wsdf_pkg::PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.payload_byte = mask_en_r ? (in_stream_byte ^ key_byte) : in_stream_byte;
        pos_nxt          = pos_r + 2'd1;
        remain_nxt       = remain_r - 24'd1;
        // The remaining count never drops below one inside a payload.
        if (remain_r == 24'd1) begin
          res.last_of_frame = 1'b1;
          phase_nxt         = wsdf_pkg::PH_HDR0;
        end
      end
      default: begin
        // First header byte, and any code outside the phase set
        phase_nxt = wsdf_pkg::PH_HDR1;
      end
    endcase

    // Header complete: oversized, empty, or start of payload
    if (chk_en) begin
      if (chk_len > {{(wsdf_pkg::LEN_W-wsdf_pkg::MAX_LEN_W){1'b0}}, max_len_r}) begin
        phase_nxt        = wsdf_pkg::PH_HDR0;
        res_valid        = 1'b1;
        res.length_error = 1'b1;
      end else if (chk_len == '0) begin
        phase_nxt       = wsdf_pkg::PH_HDR0;
        res_valid       = 1'b1;
        res.empty_frame = 1'b1;
      end else begin
        phase_nxt  = wsdf_pkg::PH_PAYLOAD;
        pos_nxt    = 2'd0;
        remain_nxt = chk_len[wsdf_pkg::MAX_LEN_W-1:0];
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsdf_pkg::PH_HDR0;
      len_r     <= '0;
      left_r    <= '0;
      key_r     <= '0;
      mask_en_r <= 1'b0;
      remain_r  <= '0;
      pos_r     <= '0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      key_r     <= key_nxt;
      mask_en_r <= mask_en_nxt;
      remain_r  <= remain_nxt;
      pos_r     <= pos_nxt;
    end
  end

  // Maximum payload length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= wsdf_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc && res_valid;
      end
    end else if (in_acc && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc && res_valid) begin
        out_r <= res;
      end
    end else if (in_acc && res_valid) begin
      skid_r <= res;
    end
  end

  assign in_stall          = skid_valid_r;
  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_last_of_frame = out_r.last_of_frame;
  assign out_length_error  = out_r.length_error;
  assign out_empty_frame   = out_r.empty_frame;

  // The skid entry is only ever filled behind a waiting result.
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a beat while the output register is empty");

  // Inside a payload at least one byte is still owed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsdf_pkg::PH_PAYLOAD) |-> (remain_r != '0))
    else $error("payload phase with no bytes remaining");

  // Error and empty-frame beats carry nothing else.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.length_error || out_r.empty_frame)) |->
      (!out_r.last_of_frame && (out_r.payload_byte == '0) &&
       !(out_r.length_error && out_r.empty_frame)))
    else $error("malformed error or empty-frame beat");

  // A beat that leaves in the last frame byte sends the parser back to a header.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_valid && res.last_of_frame) |=> (phase_r == wsdf_pkg::PH_HDR0))
    else $error("parser did not return to header after the last payload byte");

endmodule

[tb/sv/websocket_frame_deframer_tb.sv]
module websocket_frame_deframer_tb;

  localparam int CLK_PERIOD        = 20;
  localparam int RESET_CYCLES      = 5;
  localparam int SETTLE_CYCLES     = 4;
  localparam int LONG_HOLD_CYCLES  = 60;
  localparam int TIMEOUT_CYCLES    = 400000;
  localparam int MAX_SHOWN         = 10;

  typedef logic [wsdf_pkg::BYTE_W-1:0]    byte_t;
  typedef logic [wsdf_pkg::LEN_W-1:0]     len_t;
  typedef logic [wsdf_pkg::MAX_LEN_W-1:0] max_len_t;

  // How the declared length of a generated frame is encoded.
  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  // Parser state as seen by the predictor, with its own copy of the limit.
  typedef struct {
    wsdf_pkg::phase_t                phase;
    len_t                            length;
    logic [wsdf_pkg::LEFT_W-1:0]     left;
    logic [wsdf_pkg::KEY_W-1:0]      key;
    logic                            masked;
    len_t                            pos;
    max_len_t                        max_len;
  } parser_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  byte_t     in_stream_byte = '0;
  logic      cfg_wr_en = 1'b0;
  max_len_t  cfg_wr_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  byte_t     out_payload_byte;
  logic      out_last_of_frame;
  logic      out_length_error;
  logic      out_empty_frame;

  // Bytes waiting to be offered, and results the stream has earned so far.
  byte_t               pending_bytes[$];
  wsdf_pkg::result_t   expected_beats[$];

  // The live parser follows accepted beats; the plan parser follows queued bytes.
  parser_t live_parser;
  parser_t plan_parser;

  bit          beat_taken = 1'b0;
  bit          send_gaps_on = 1'b1;
  bit          recv_gaps_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned long_holds_asked = 0;
  int unsigned long_holds_done = 0;
  int unsigned bytes_planned = 0;
  int unsigned results_seen = 0;
  int unsigned failures = 0;

  websocket_frame_deframer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_length_error  (out_length_error),
    .out_empty_frame   (out_empty_frame)
  );

  function automatic parser_t parser_reset();
    parser_t st;
    st.phase   = wsdf_pkg::PH_HDR0;
    st.length  = '0;
    st.left    = '0;
    st.key     = '0;
    st.masked  = 1'b0;
    st.pos     = '0;
    st.max_len = wsdf_pkg::MAX_LEN_RESET;
    return st;
  endfunction

  // Called once the length is known, and again once the key is in. A masked
  // frame first collects its key; then the length is checked against the limit.
  function automatic bit close_header(inout parser_t st, input bit key_done,
                                      output wsdf_pkg::result_t r);
    bit produced;
    r = '0;
    produced = 1'b0;
    if (st.masked && !key_done) begin
      st.phase = wsdf_pkg::PH_KEY;
      st.left  = wsdf_pkg::KEY_BYTES;
    end else if (st.length > len_t'(st.max_len)) begin
      st.phase = wsdf_pkg::PH_HDR0;
      r.length_error = 1'b1;
      produced = 1'b1;
    end else if (st.length == '0) begin
      st.phase = wsdf_pkg::PH_HDR0;
      r.empty_frame = 1'b1;
      produced = 1'b1;
    end else begin
      st.pos   = '0;
      st.phase = wsdf_pkg::PH_PAYLOAD;
    end
    return produced;
  endfunction

  // Advances the parser by one stream byte; returns 1 when a result comes out.
  function automatic bit deframe_step(inout parser_t st, input byte_t b,
                                      output wsdf_pkg::result_t r);
    bit         produced;
    logic [6:0] code;
    byte_t      key_byte;
    r = '0;
    produced = 1'b0;
    code = b[6:0];
    key_byte = st.key[(3 - st.pos[1:0]) * 8 +: 8];
    case (st.phase)
      wsdf_pkg::PH_HDR1: begin
        st.masked = b[wsdf_pkg::MASK_BIT];
        st.key    = '0;
        st.length = '0;
        if (code == wsdf_pkg::LEN_CODE_16) begin
          st.left  = wsdf_pkg::EXT16_BYTES;
          st.phase = wsdf_pkg::PH_EXTLEN;
        end else if (code == wsdf_pkg::LEN_CODE_64) begin
          st.left  = wsdf_pkg::EXT64_BYTES;
          st.phase = wsdf_pkg::PH_EXTLEN;
        end else begin
          st.length = len_t'(code);
          produced = close_header(st, 1'b0, r);
        end
      end
      wsdf_pkg::PH_EXTLEN: begin
        st.length = {st.length[wsdf_pkg::LEN_W-9:0], b};
        st.left   = st.left - 4'd1;
        if (st.left == '0) begin
          produced = close_header(st, 1'b0, r);
        end
      end
      wsdf_pkg::PH_KEY: begin
        st.key  = {st.key[wsdf_pkg::KEY_W-9:0], b};
        st.left = st.left - 4'd1;
        if (st.left == '0) begin
          produced = close_header(st, 1'b1, r);
        end
      end
      wsdf_pkg::PH_PAYLOAD: begin
        r.payload_byte  = st.masked ? (b ^ key_byte) : b;
        st.pos          = st.pos + 64'd1;
        r.last_of_frame = (st.pos >= st.length);
        if (r.last_of_frame) begin
          st.phase = wsdf_pkg::PH_HDR0;
        end
        produced = 1'b1;
      end
      default: begin
        st.phase = wsdf_pkg::PH_HDR1;
      end
    endcase
    return produced;
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 60) begin
      return 0;
    end else if (roll < 88) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(16, 40);
  endfunction

  task automatic push_byte(input byte_t b);
    wsdf_pkg::result_t unused;
    pending_bytes.push_back(b);
    void'(deframe_step(plan_parser, b, unused));
    bytes_planned++;
  endtask

  // One well-formed frame with random content, starting from a fresh header.
  task automatic add_frame();
    len_t         len;
    max_len_t     limit;
    logic         masked;
    int unsigned  roll;
    len_form_t    form;
    limit  = plan_parser.max_len;
    masked = 1'($urandom_range(0, 1));
    roll   = $urandom_range(0, 99);
    if (roll < 15) begin
      len = '0;
    end else if (roll < 55) begin
      len = len_t'($urandom_range(1, 8));
    end else if (roll < 70) begin
      len = len_t'($urandom_range(9, 40));
    end else if (roll < 78) begin
      len = (limit <= 64) ? len_t'(limit) : len_t'($urandom_range(1, 40));
    end else if (roll < 86) begin
      len = len_t'(limit) + 64'd1;
    end else begin
      len = {$urandom, $urandom};
      if (len <= len_t'(limit)) begin
        len = len_t'(limit) + 64'd1 + len_t'($urandom_range(0, 999));
      end
    end

    // Pick a legal encoding, not always the shortest one.
    roll = $urandom_range(0, 9);
    if (len <= 125) begin
      form = (roll < 7) ? LEN_SHORT : ((roll < 9) ? LEN_EXT16 : LEN_EXT64);
    end else if (len <= 65535) begin
      form = (roll < 5) ? LEN_EXT16 : LEN_EXT64;
    end else begin
      form = LEN_EXT64;
    end

    push_byte(8'($urandom));
    case (form)
      LEN_SHORT: begin
        push_byte({masked, len[6:0]});
      end
      LEN_EXT16: begin
        push_byte({masked, wsdf_pkg::LEN_CODE_16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({masked, wsdf_pkg::LEN_CODE_64});
        for (int i = 7; i >= 0; i--) begin
          push_byte(len[i*8 +: 8]);
        end
      end
    endcase
    if (masked) begin
      repeat (4) push_byte(8'($urandom));
    end
    if (len != '0 && len <= len_t'(limit)) begin
      repeat (int'(len)) push_byte(8'($urandom));
    end
  endtask

  // A few random bytes, then filler that brings the parser back to a header
  // boundary within a bounded number of bytes. Bursts that would need a long
  // payload to finish are thrown away and redrawn.
  task automatic add_noise();
    parser_t            trial;
    wsdf_pkg::result_t  unused;
    byte_t              burst[$];
    byte_t              b;
    for (int attempt = 0; attempt < 20; attempt++) begin
      trial = plan_parser;
      burst.delete();
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom);
        burst.push_back(b);
        void'(deframe_step(trial, b, unused));
      end
      while (trial.phase != wsdf_pkg::PH_HDR0 && burst.size() < 160) begin
        case (trial.phase)
          wsdf_pkg::PH_HDR1:   b = {1'($urandom), 7'($urandom_range(0, 12))};
          wsdf_pkg::PH_EXTLEN: b = (trial.left == 1) ? 8'($urandom_range(0, 12)) : 8'h00;
          default:             b = 8'($urandom);
        endcase
        burst.push_back(b);
        void'(deframe_step(trial, b, unused));
      end
      if (trial.phase == wsdf_pkg::PH_HDR0) begin
        foreach (burst[i]) begin
          push_byte(burst[i]);
        end
        return;
      end
    end
  endtask

  task automatic random_stream(input int unsigned count);
    int unsigned start;
    start = bytes_planned;
    while (bytes_planned - start < count) begin
      if ($urandom_range(0, 99) < 85) begin
        add_frame();
      end else begin
        add_noise();
      end
    end
  endtask

  // Sender out of bytes and every earned result delivered, then a settling wait
  // for header bytes still working through the parser.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max(input max_len_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    plan_parser.max_len = value;
    live_parser.max_len = value;
  endtask

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("websocket_frame_deframer_tb NOT OK");
    $finish;
  end

  // Input side: a beat is taken when valid is high and stall is low.
  always @(posedge clk) begin : take_input
    wsdf_pkg::result_t beat;
    if (rst_n && in_valid && !in_stall) begin
      void'(pending_bytes.pop_front());
      beat_taken = 1'b1;
      if (deframe_step(live_parser, in_stream_byte, beat)) begin
        expected_beats.push_back(beat);
      end
    end
  end

  // Sender: holds a stalled beat, otherwise offers the next byte or idles.
  always @(negedge clk) begin
    if (!in_valid || beat_taken) begin
      if (send_gap != 0) begin
        in_valid       <= 1'b0;
        in_stream_byte <= 8'($urandom);
        send_gap--;
      end else if (pending_bytes.size() != 0) begin
        in_valid       <= 1'b1;
        in_stream_byte <= pending_bytes[0];
        send_gap = pick_gap(send_gaps_on);
      end else begin
        in_valid <= 1'b0;
      end
    end
    beat_taken = 1'b0;
  end

  // Receiver: random stall runs, plus a long hold-off when one is asked for.
  always @(negedge clk) begin
    if (long_holds_asked != long_holds_done) begin
      hold_left = LONG_HOLD_CYCLES;
      long_holds_done++;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(recv_gaps_on);
    end
  end

  // Output side: each result beat is checked against the oldest expectation.
  always @(posedge clk) begin : check_output
    wsdf_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_beats.size() == 0) begin
        failures++;
        if (failures <= MAX_SHOWN) begin
          $display("unexpected result beat %0d: byte %02h last %0b err %0b empty %0b",
                   results_seen, out_payload_byte, out_last_of_frame,
                   out_length_error, out_empty_frame);
        end
      end else begin
        want = expected_beats.pop_front();
        if (out_payload_byte !== want.payload_byte ||
            out_last_of_frame !== want.last_of_frame ||
            out_length_error !== want.length_error ||
            out_empty_frame !== want.empty_frame) begin
          failures++;
          if (failures <= MAX_SHOWN) begin
            $display("result beat %0d: expected byte %02h last %0b err %0b empty %0b",
                     results_seen, want.payload_byte, want.last_of_frame,
                     want.length_error, want.empty_frame);
            $display("  got byte %02h last %0b err %0b empty %0b",
                     out_payload_byte, out_last_of_frame, out_length_error,
                     out_empty_frame);
          end
        end
      end
    end
  end

  initial begin
    live_parser = parser_reset();
    plan_parser = parser_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset limit: an empty frame, a masked frame with
    // a 16-bit length whose payload wraps the key, and a 64-bit length one
    // byte over the limit.
    push_byte(8'h81);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte({1'b1, wsdf_pkg::LEN_CODE_16});
    push_byte(8'h00);
    push_byte(8'h05);
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(8'h56);
    push_byte(8'h78);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hA5);
    push_byte(8'h5A);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte({1'b0, wsdf_pkg::LEN_CODE_64});
    for (int i = 7; i >= 0; i--) begin
      push_byte((i == 1) ? 8'h10 : ((i == 0) ? 8'h01 : 8'h00));
    end
    random_stream(120);
    wait_drained();

    // Zero limit: every frame that declares a payload is rejected.
    write_max('0);
    random_stream(50);
    wait_drained();

    // Largest limit, with a long receiver hold-off while bytes keep coming.
    write_max('1);
    long_holds_asked++;
    random_stream(130);
    wait_drained();

    // Limit changed in the middle of a header, before the length arrives.
    push_byte(8'h82);
    push_byte({1'b1, wsdf_pkg::LEN_CODE_16});
    wait_drained();
    write_max(24'd20);
    push_byte(8'h00);
    push_byte(8'h14);
    repeat (4) push_byte(8'($urandom));
    repeat (20) push_byte(8'($urandom));
    random_stream(100);
    wait_drained();

    // Both sides run flat out with a limit of one byte.
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    write_max(24'd1);
    random_stream(60);
    wait_drained();
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;

    write_max(max_len_t'($urandom_range(2, 64)));
    random_stream(140);
    wait_drained();

    if (failures == 0 && expected_beats.size() == 0) begin
      $display("websocket_frame_deframer_tb OK");
    end else begin
      $display("websocket_frame_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule
